/* hw/rtl/ihsc_pkg.sv */
package ihsc_pkg;

  // Default number of leading file bytes that the parser looks at.
  localparam int unsigned SCAN_LIMIT_DEF = 1048576;

  // Image format codes as reported on the result stream.
  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_JPEG    = 2'd1;
  localparam logic [1:0] FMT_PNG     = 2'd2;
  localparam logic [1:0] FMT_BMP     = 2'd3;

  // JPEG marker walk phases.
  localparam int unsigned PH_W = 3;
  localparam logic [PH_W-1:0] PH_SEEK   = 3'd0;
  localparam logic [PH_W-1:0] PH_FF     = 3'd1;
  localparam logic [PH_W-1:0] PH_LEN_HI = 3'd2;
  localparam logic [PH_W-1:0] PH_LEN_LO = 3'd3;
  localparam logic [PH_W-1:0] PH_SOF    = 3'd4;
  localparam logic [PH_W-1:0] PH_SKIP   = 3'd5;
  localparam logic [PH_W-1:0] PH_DONE   = 3'd6;

  // Signature and marker bytes.
  localparam logic [7:0]  JPEG_SOI_0   = 8'hFF;
  localparam logic [7:0]  JPEG_SOI_1   = 8'hD8;
  localparam logic [7:0]  BMP_SIG_0    = 8'h42;
  localparam logic [7:0]  BMP_SIG_1    = 8'h4D;
  localparam logic [7:0]  PNG_SIG_0    = 8'h89;
  localparam logic [23:0] PNG_SIG_REST = 24'h504E47;
  localparam logic [7:0]  MARKER_PFX   = 8'hFF;
  localparam logic [7:0]  SOF_FIRST    = 8'hC0;
  localparam logic [7:0]  SOF_LAST     = 8'hC3;

  // Configuration register map.
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MIN_WIDTH  = 1'b0;
  localparam logic REG_MIN_HEIGHT = 1'b1;

  // What the parser reports for the beat it is taking.
  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] width;
    logic [31:0] height;
  } ihsc_result_t;

endpackage

/* hw/rtl/ihsc_parse.sv */
module ihsc_parse
  import ihsc_pkg::*;
#(
  parameter int unsigned SCAN_LIMIT = SCAN_LIMIT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         beat_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output ihsc_result_t result_o
);

  localparam int unsigned PosW = $clog2(SCAN_LIMIT + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      fmt_q, fmt_d;
  logic [7:0]      first_q, first_d;
  logic [PH_W-1:0] phase_q, phase_d;
  logic [15:0]     skip_q, skip_d;
  logic [7:0]      lenhi_q, lenhi_d;
  logic [31:0]     wid_q, wid_d;
  logic [31:0]     hgt_q, hgt_d;
  logic            done_q, done_d;
  logic [15:0]     seg_len;
  logic [15:0]     skip_dec;

  assign seg_len  = {lenhi_q, byte_i};
  assign skip_dec = skip_q - 16'd1;

  // State update for one file byte.
  always_comb begin
    pos_d   = pos_q;
    fmt_d   = fmt_q;
    first_d = first_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    lenhi_d = lenhi_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    done_d  = done_q;
    if (pos_q < PosW'(SCAN_LIMIT)) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == PosW'(0)) begin
        first_d = byte_i;
      end else if (pos_q <= PosW'(3) && fmt_q == FMT_UNKNOWN) begin
        // Signature bytes collect in the width register until typed.
        wid_d = {wid_q[23:0], byte_i};
        if (pos_q == PosW'(1)) begin
          if (first_q == JPEG_SOI_0 && byte_i == JPEG_SOI_1) begin
            fmt_d = FMT_JPEG;
            wid_d = '0;
          end else if (first_q == BMP_SIG_0 && byte_i == BMP_SIG_1) begin
            fmt_d = FMT_BMP;
            wid_d = '0;
          end
        end else if (pos_q == PosW'(3)) begin
          if (first_q == PNG_SIG_0 && wid_d[23:0] == PNG_SIG_REST) begin
            fmt_d = FMT_PNG;
          end
          wid_d = '0;
        end
      end else if (!done_q) begin
        case (fmt_q)
          FMT_JPEG: begin
            // Segment marker walk.
            case (phase_q)
              PH_SEEK: begin
                if (byte_i == MARKER_PFX) phase_d = PH_FF;
              end
              PH_FF: begin
                if (byte_i != MARKER_PFX) begin
                  if (byte_i >= SOF_FIRST && byte_i <= SOF_LAST) begin
                    phase_d = PH_SOF;
                    skip_d  = 16'd1;
                  end else begin
                    phase_d = PH_LEN_HI;
                  end
                end
              end
              PH_LEN_HI: begin
                lenhi_d = byte_i;
                phase_d = PH_LEN_LO;
              end
              PH_LEN_LO: begin
                if (seg_len <= 16'd2) begin
                  phase_d = PH_SEEK;
                end else begin
                  skip_d  = seg_len - 16'd2;
                  phase_d = PH_SKIP;
                end
              end
              PH_SKIP: begin
                skip_d = skip_dec;
                if (skip_dec == 16'd0) phase_d = PH_SEEK;
              end
              PH_SOF: begin
                if (skip_q == 16'd4 || skip_q == 16'd5) begin
                  hgt_d = {16'd0, hgt_q[7:0], byte_i};
                end else if (skip_q == 16'd6 || skip_q == 16'd7) begin
                  wid_d = {16'd0, wid_q[7:0], byte_i};
                end
                if (skip_q >= 16'd7) begin
                  done_d  = 1'b1;
                  phase_d = PH_DONE;
                end else begin
                  skip_d = skip_q + 16'd1;
                end
              end
              default: ;
            endcase
          end
          FMT_PNG: begin
            // Big-endian width then height at fixed offsets.
            if (pos_q >= PosW'(16) && pos_q <= PosW'(19)) begin
              wid_d = {wid_q[23:0], byte_i};
            end else if (pos_q >= PosW'(20) && pos_q <= PosW'(23)) begin
              hgt_d = {hgt_q[23:0], byte_i};
            end
            if (pos_q == PosW'(23)) done_d = 1'b1;
          end
          FMT_BMP: begin
            // Little-endian width then height at fixed offsets.
            case (pos_q)
              PosW'(18): wid_d[7:0]   = wid_q[7:0]   | byte_i;
              PosW'(19): wid_d[15:8]  = wid_q[15:8]  | byte_i;
              PosW'(20): wid_d[23:16] = wid_q[23:16] | byte_i;
              PosW'(21): wid_d[31:24] = wid_q[31:24] | byte_i;
              PosW'(22): hgt_d[7:0]   = hgt_q[7:0]   | byte_i;
              PosW'(23): hgt_d[15:8]  = hgt_q[15:8]  | byte_i;
              PosW'(24): hgt_d[23:16] = hgt_q[23:16] | byte_i;
              PosW'(25): hgt_d[31:24] = hgt_q[31:24] | byte_i;
              default: ;
            endcase
            if (pos_q == PosW'(25)) done_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Result as seen after this byte; dimensions only once complete.
  assign result_o.fmt    = fmt_d;
  assign result_o.width  = done_d ? wid_d : 32'd0;
  assign result_o.height = done_d ? hgt_d : 32'd0;

  // Parse state; the final byte of a file clears it for the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fmt_q   <= FMT_UNKNOWN;
      first_q <= '0;
      phase_q <= PH_SEEK;
      skip_q  <= '0;
      lenhi_q <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      done_q  <= 1'b0;
    end else if (beat_i) begin
      if (last_i) begin
        pos_q   <= '0;
        fmt_q   <= FMT_UNKNOWN;
        first_q <= '0;
        phase_q <= PH_SEEK;
        skip_q  <= '0;
        lenhi_q <= '0;
        wid_q   <= '0;
        hgt_q   <= '0;
        done_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        fmt_q   <= fmt_d;
        first_q <= first_d;
        phase_q <= phase_d;
        skip_q  <= skip_d;
        lenhi_q <= lenhi_d;
        wid_q   <= wid_d;
        hgt_q   <= hgt_d;
        done_q  <= done_d;
      end
    end
  end

`ifndef SYNTHESIS
  // Dimensions can only be complete once a format has been recognized.
  a_done_needs_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> fmt_q != FMT_UNKNOWN)
    else $error("dimensions complete without a format");

  // The scan position never runs past the limit.
  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(SCAN_LIMIT))
    else $error("scan position beyond limit");

  // Only a JPEG file moves the marker walk off its idle phase.
  a_phase_jpeg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SEEK |-> fmt_q == FMT_JPEG)
    else $error("marker walk active for a non-JPEG file");
`endif

endmodule

/* hw/rtl/image_header_size_check_top.sv */
// Image header size check, one file byte per beat.
// The result beat is valid in the cycle after the beat carrying the final byte.
// Throughput: one byte per cycle; the input stays ready while a result waits, unless
// the output register is full and not being taken.
// Reset (rst_ni low, asynchronous): parse state cleared, both minimums zero, no result.
module image_header_size_check_top
  import ihsc_pkg::*;
#(
  parameter int unsigned SCAN_LIMIT = SCAN_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Byte stream in.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // last_byte
  // Result stream out.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [71:0]       m_axis_tdata,   // [0] accepted, [32:1] image_width,
                                            // [64:33] image_height, [71:65] zero
  output logic [1:0]        m_axis_tuser,   // [1:0] image_format
  // Configuration.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic         s_fire;
  logic         cfg_wr;
  logic [31:0]  min_w_q;
  logic [31:0]  min_h_q;
  ihsc_result_t res;
  logic         ok;
  logic         out_vld_q;
  logic         out_acc_q;
  logic [1:0]   out_fmt_q;
  logic [31:0]  out_w_q;
  logic [31:0]  out_h_q;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_vld_q || m_axis_tready;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_w_q <= '0;
      min_h_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_WIDTH) min_w_q <= pwdata;
      else                           min_h_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_MIN_HEIGHT) ? min_h_q : min_w_q;

  // Header parser.
  ihsc_parse #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (s_fire),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .result_o(res)
  );

  // Size selection rule.
  always_comb begin
    if (min_w_q == 32'd0 && min_h_q == 32'd0) begin
      ok = 1'b1;
    end else begin
      ok = (res.width != 32'd0) && (res.height != 32'd0) &&
           (min_w_q == 32'd0 || res.width >= min_w_q) &&
           (min_h_q == 32'd0 || res.height >= min_h_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tlast) begin
      out_acc_q <= ok;
      out_fmt_q <= res.fmt;
      out_w_q   <= res.width;
      out_h_q   <= res.height;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_h_q, out_w_q, out_acc_q};
  assign m_axis_tuser  = out_fmt_q;

`ifndef SYNTHESIS
  // A final byte always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> m_axis_tvalid)
    else $error("final byte did not produce a result");

  // A taken result is not repeated without a new final byte.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !(s_fire && s_axis_tlast) |=> !m_axis_tvalid)
    else $error("result repeated");

  // An unknown format never reports dimensions.
  a_unknown_no_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == FMT_UNKNOWN |->
      m_axis_tdata[32:1] == 32'd0 && m_axis_tdata[64:33] == 32'd0)
    else $error("dimensions reported for unknown format");

  // With a size test enabled, a zero width cannot be accepted.
  a_zero_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32:1] == 32'd0 &&
      (min_w_q != 32'd0 || min_h_q != 32'd0) && $stable(min_w_q) && $stable(min_h_q)
      |-> !m_axis_tdata[0])
    else $error("zero width accepted under an active size test");
`endif

endmodule

/* test/tb_image_header_size_check_top.sv */
`timescale 1ns / 1ps

module tb_image_header_size_check_top;
  import ihsc_pkg::*;

  // A small scan window keeps long files and the saturation case cheap.
  localparam int unsigned TB_SCAN     = 96;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Marker codes used to build filler segments in JPEG streams.
  localparam logic [7:0] MK_STUFF = 8'h00;
  localparam logic [7:0] MK_DHT   = 8'hC4;
  localparam logic [7:0] MK_EOI   = 8'hD9;
  localparam logic [7:0] MK_DQT   = 8'hDB;
  localparam logic [7:0] MK_APP0  = 8'hE0;
  localparam logic [7:0] MK_APP1  = 8'hE1;

  typedef enum {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  fmt;
    logic [31:0] width;
    logic [31:0] height;
  } size_verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [71:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  image_header_size_check_top #(
    .SCAN_LIMIT(TB_SCAN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Testbench bookkeeping.
  file_beat_t    pending_bytes[$];
  size_verdict_t expected_results[$];
  logic [7:0]    file_buf[$];
  int unsigned   queued_total = 0;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_left = 0;
  bit            byte_taken = 1'b0;
  pace_e         pace_mode = PACE_FULL;

  // Shadow of the parser state and the minimum registers.
  int unsigned   scan_pos = 0;
  logic [1:0]    fmt_st = FMT_UNKNOWN;
  logic [7:0]    lead_byte = '0;
  logic [2:0]    walk_ph = PH_SEEK;
  logic [15:0]   skip_cnt = '0;
  logic [7:0]    seg_len_hi = '0;
  logic [31:0]   wid_acc = '0;
  logic [31:0]   hgt_acc = '0;
  logic          dims_ok = 1'b0;
  logic [31:0]   min_w_reg = '0;
  logic [31:0]   min_h_reg = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t mismatch, %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic clear_parse_state();
    scan_pos   = 0;
    fmt_st     = FMT_UNKNOWN;
    lead_byte  = '0;
    walk_ph    = PH_SEEK;
    skip_cnt   = '0;
    seg_len_hi = '0;
    wid_acc    = '0;
    hgt_acc    = '0;
    dims_ok    = 1'b0;
  endtask

  // One step of the JPEG segment walk.
  task automatic jpeg_walk_step(input logic [7:0] b);
    logic [15:0] seg_len;
    case (walk_ph)
      PH_SEEK: begin
        if (b == MARKER_PFX) walk_ph = PH_FF;
      end
      PH_FF: begin
        if (b != MARKER_PFX) begin
          if (b >= SOF_FIRST && b <= SOF_LAST) begin
            walk_ph  = PH_SOF;
            skip_cnt = 16'd1;
          end else begin
            walk_ph = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        seg_len_hi = b;
        walk_ph    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len = {seg_len_hi, b};
        if (seg_len <= 16'd2) begin
          walk_ph = PH_SEEK;
        end else begin
          skip_cnt = seg_len - 16'd2;
          walk_ph  = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 16'd1;
        if (skip_cnt == 16'd0) walk_ph = PH_SEEK;
      end
      PH_SOF: begin
        // Frame header: length, precision, then height and width big-endian.
        if (skip_cnt == 16'd4 || skip_cnt == 16'd5) hgt_acc = {16'h0, hgt_acc[7:0], b};
        else if (skip_cnt == 16'd6 || skip_cnt == 16'd7) wid_acc = {16'h0, wid_acc[7:0], b};
        if (skip_cnt >= 16'd7) begin
          dims_ok = 1'b1;
          walk_ph = PH_DONE;
        end else begin
          skip_cnt = skip_cnt + 16'd1;
        end
      end
      default: ;
    endcase
  endtask

  // Parse one byte that lies inside the scan window.
  task automatic take_file_byte(input logic [7:0] b);
    int unsigned pos;
    pos = scan_pos;
    scan_pos = pos + 1;
    if (pos == 0) begin
      lead_byte = b;
    end else if (pos <= 3 && fmt_st == FMT_UNKNOWN) begin
      // Signature detection borrows the width accumulator.
      wid_acc = {wid_acc[23:0], b};
      if (pos == 1) begin
        if (lead_byte == JPEG_SOI_0 && b == JPEG_SOI_1) begin
          fmt_st  = FMT_JPEG;
          wid_acc = '0;
        end else if (lead_byte == BMP_SIG_0 && b == BMP_SIG_1) begin
          fmt_st  = FMT_BMP;
          wid_acc = '0;
        end
      end else if (pos == 3) begin
        if (lead_byte == PNG_SIG_0 && wid_acc[23:0] == PNG_SIG_REST) fmt_st = FMT_PNG;
        wid_acc = '0;
      end
    end else if (!dims_ok) begin
      case (fmt_st)
        FMT_JPEG: jpeg_walk_step(b);
        FMT_PNG: begin
          if (pos >= 16 && pos <= 19) wid_acc = {wid_acc[23:0], b};
          else if (pos >= 20 && pos <= 23) hgt_acc = {hgt_acc[23:0], b};
          if (pos == 23) dims_ok = 1'b1;
        end
        FMT_BMP: begin
          if (pos >= 18 && pos <= 21) wid_acc = wid_acc | ({24'h0, b} << (8 * (pos - 18)));
          else if (pos >= 22 && pos <= 25) hgt_acc = hgt_acc | ({24'h0, b} << (8 * (pos - 22)));
          if (pos == 25) dims_ok = 1'b1;
        end
        default: ;
      endcase
    end
  endtask

  // Advance the shadow parser by one accepted beat; the final byte yields a verdict.
  task automatic predict_size_verdict(input logic [7:0] b, input logic last);
    size_verdict_t v;
    if (scan_pos < TB_SCAN) take_file_byte(b);
    if (last) begin
      v.fmt    = fmt_st;
      v.width  = dims_ok ? wid_acc : 32'h0;
      v.height = dims_ok ? hgt_acc : 32'h0;
      if (min_w_reg == 0 && min_h_reg == 0) v.accepted = 1'b1;
      else v.accepted = v.width != 0 && v.height != 0 &&
                        (min_w_reg == 0 || v.width >= min_w_reg) &&
                        (min_h_reg == 0 || v.height >= min_h_reg);
      expected_results.insert(expected_results.size(), v);
      clear_parse_state();
    end
  endtask

  function automatic bit sender_rests();
    case (pace_mode)
      PACE_SRC_GAPS: return $urandom_range(99) < 82;
      PACE_BOTH:     return $urandom_range(99) < 11;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (pace_mode)
      PACE_SINK_STALLS: return $urandom_range(99) < 82;
      PACE_BOTH:        return $urandom_range(99) < 11;
      default:          return 1'b0;
    endcase
  endfunction

  // Byte driver: presents the next queued beat once the current one is taken.
  always @(negedge clk_i) begin : byte_driver
    if (rst_ni && (!s_axis_tvalid || byte_taken)) begin
      if (pending_bytes.size() != 0 && !sender_rests()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bytes[0].data;
        s_axis_tlast  <= pending_bytes[0].last;
        pending_bytes.delete(0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink, with an optional long hold-off to back the block up.
  always @(negedge clk_i) begin : result_sink
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && !sink_stalls();
    end
  end

  // Monitor: checks result beats, then feeds accepted input beats to the predictor.
  always @(posedge clk_i) begin : beat_monitor
    size_verdict_t want;
    if (rst_ni) begin
      cycle_count++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", {30'h0, m_axis_tuser}, 32'h0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (m_axis_tdata[0] != want.accepted)
            report_mismatch("accepted", {31'h0, m_axis_tdata[0]}, {31'h0, want.accepted});
          if (m_axis_tuser != want.fmt)
            report_mismatch("image_format", {30'h0, m_axis_tuser}, {30'h0, want.fmt});
          if (m_axis_tdata[32:1] != want.width)
            report_mismatch("image_width", m_axis_tdata[32:1], want.width);
          if (m_axis_tdata[64:33] != want.height)
            report_mismatch("image_height", m_axis_tdata[64:33], want.height);
          if (m_axis_tdata[71:65] != 7'h0)
            report_mismatch("tdata pad bits", {25'h0, m_axis_tdata[71:65]}, 32'h0);
        end
      end
      byte_taken = s_axis_tvalid && s_axis_tready;
      if (byte_taken) predict_size_verdict(s_axis_tdata, s_axis_tlast);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[image_header_size_check_top] ERROR");
      $finish;
    end
  end

  task automatic add_beat(input logic [7:0] b, input logic last);
    file_beat_t fb;
    fb.data = b;
    fb.last = last;
    pending_bytes.insert(pending_bytes.size(), fb);
    queued_total++;
  endtask

  // Queue the first len bytes of the file buffer, marking the final one.
  task automatic push_file(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) add_beat(file_buf[i], i == len - 1);
  endtask

  // Append one byte to the file being built.
  task automatic buf_put(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // JPEG: start of image, a few filler segments, then a frame header.
  task automatic build_jpeg(input logic [15:0] w, input logic [15:0] h);
    int unsigned n_seg, seg_len, body;
    logic [7:0]  mk;
    buf_put(JPEG_SOI_0);
    buf_put(JPEG_SOI_1);
    n_seg = $urandom_range(0, 3);
    for (int unsigned s = 0; s < n_seg; s++) begin
      if ($urandom_range(3) == 0) buf_put(MARKER_PFX);
      buf_put(MARKER_PFX);
      case ($urandom_range(5))
        0:       mk = MK_APP0;
        1:       mk = MK_DQT;
        2:       mk = MK_DHT;
        3:       mk = MK_STUFF;
        4:       mk = MK_EOI;
        default: mk = 8'($urandom);
      endcase
      if ((mk >= SOF_FIRST && mk <= SOF_LAST) || mk == MARKER_PFX) mk = MK_APP1;
      buf_put(mk);
      case ($urandom_range(19))
        0, 1, 2: seg_len = $urandom_range(0, 2);
        3:       seg_len = $urandom_range(150, 65535);
        default: seg_len = $urandom_range(3, 14);
      endcase
      buf_put(8'(seg_len >> 8));
      buf_put(8'(seg_len));
      // Long segments run past the scan window, so only part of them is sent.
      body = (seg_len > 2) ? seg_len - 2 : 0;
      if (body > 60) body = 60;
      for (int unsigned i = 0; i < body; i++) buf_put(8'($urandom));
      if ($urandom_range(9) == 0) begin
        mk = 8'($urandom);
        buf_put(mk == MARKER_PFX ? MK_STUFF : mk);
      end
    end
    buf_put(MARKER_PFX);
    buf_put(SOF_FIRST + 8'($urandom_range(3)));
    buf_put(8'h00);
    buf_put(8'h11);
    buf_put(8'h08);
    buf_put(h[15:8]);
    buf_put(h[7:0]);
    buf_put(w[15:8]);
    buf_put(w[7:0]);
    for (int unsigned i = 0; i < 3; i++) buf_put(8'($urandom));
  endtask

  // One random file: mostly well-formed headers, some cut short, some noise.
  task automatic add_random_file();
    int unsigned kind, len, target;
    logic [31:0] w, h;
    file_buf.delete();
    kind = $urandom_range(99);
    w = pick_dim();
    h = pick_dim();
    if (kind < 80) begin
      if (kind < 30) begin
        buf_put(PNG_SIG_0);
        buf_put(PNG_SIG_REST[23:16]);
        buf_put(PNG_SIG_REST[15:8]);
        buf_put(PNG_SIG_REST[7:0]);
        for (int unsigned i = 4; i < 16; i++) buf_put(8'($urandom));
        for (int i = 3; i >= 0; i--) buf_put(8'(w >> (8 * i)));
        for (int i = 3; i >= 0; i--) buf_put(8'(h >> (8 * i)));
        // Occasionally spoil one signature bit.
        if ($urandom_range(9) == 0) begin
          len = $urandom_range(3);
          file_buf[len] = file_buf[len] ^ (8'h01 << $urandom_range(7));
        end
      end else if (kind < 55) begin
        buf_put(BMP_SIG_0);
        buf_put(BMP_SIG_1);
        for (int unsigned i = 2; i < 18; i++) buf_put(8'($urandom));
        for (int i = 0; i < 4; i++) buf_put(8'(w >> (8 * i)));
        for (int i = 0; i < 4; i++) buf_put(8'(h >> (8 * i)));
      end else begin
        build_jpeg(w[15:0], h[15:0]);
      end
      for (int unsigned i = $urandom_range(12); i > 0; i--) buf_put(8'($urandom));
      if ($urandom_range(19) == 0) begin
        target = TB_SCAN + $urandom_range(1, 20);
        while (file_buf.size() < target) buf_put(8'($urandom));
      end
      len = ($urandom_range(99) < 15) ? $urandom_range(1, file_buf.size()) : file_buf.size();
      push_file(len);
    end else begin
      // Noise, sometimes behind a JPEG start so the walk runs over garbage.
      len = $urandom_range(1, 40);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(2) == 0 && i < 2)
          add_beat(i == 0 ? JPEG_SOI_0 : JPEG_SOI_1, i == len - 1);
        else
          add_beat(8'($urandom), i == len - 1 || $urandom_range(7) == 0);
      end
    end
  endtask

  // Wait until every beat is sent and every verdict is back.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_MIN_WIDTH) min_w_reg = value;
    else min_h_reg = value;
  endtask

  task automatic cfg_readback(input logic reg_sel);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == REG_MIN_WIDTH && got != min_w_reg)
      report_mismatch("min_width readback", got, min_w_reg);
    if (reg_sel == REG_MIN_HEIGHT && got != min_h_reg)
      report_mismatch("min_height readback", got, min_h_reg);
  endtask

  task automatic set_minimums(input logic [31:0] w, input logic [31:0] h);
    cfg_write(REG_MIN_WIDTH, w);
    cfg_write(REG_MIN_HEIGHT, h);
    cfg_readback(REG_MIN_WIDTH);
    cfg_readback(REG_MIN_HEIGHT);
  endtask

  // One random phase; with a hold-off, tiny files go first so results pile up.
  task automatic run_phase(input pace_e pace, input int unsigned n_items, input bit hold);
    int unsigned start;
    int unsigned n;
    start = queued_total;
    pace_mode = pace;
    if (hold) begin
      while (queued_total - start < 40) begin
        n = $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++) add_beat(8'($urandom), i == n - 1);
      end
      hold_left = HOLD_CYCLES;
    end
    while (queued_total - start < n_items) add_random_file();
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both minimums come out of reset as zero.
    cfg_readback(REG_MIN_WIDTH);
    cfg_readback(REG_MIN_HEIGHT);

    // Directed: one-byte file, bare BMP signature, short PNG, near-PNG, minimal SOF1.
    add_beat(8'hAA, 1'b1);
    add_beat(BMP_SIG_0, 1'b0);
    add_beat(BMP_SIG_1, 1'b1);
    add_beat(PNG_SIG_0, 1'b0);
    add_beat(PNG_SIG_REST[23:16], 1'b0);
    add_beat(PNG_SIG_REST[15:8], 1'b1);
    add_beat(PNG_SIG_0, 1'b0);
    add_beat(PNG_SIG_REST[23:16], 1'b0);
    add_beat(PNG_SIG_REST[15:8], 1'b0);
    add_beat(8'h46, 1'b1);
    add_beat(JPEG_SOI_0, 1'b0);
    add_beat(JPEG_SOI_1, 1'b0);
    add_beat(MARKER_PFX, 1'b0);
    add_beat(SOF_FIRST + 8'd1, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h11, 1'b0);
    add_beat(8'h08, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h05, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h07, 1'b1);
    wait_idle();

    // Random phases over a spread of minimums and pacing.
    set_minimums(32'd200, 32'd150);
    run_phase(PACE_FULL, 250, 1'b1);
    set_minimums(32'd0, 32'd1);
    run_phase(PACE_SRC_GAPS, 250, 1'b0);
    set_minimums(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(PACE_SINK_STALLS, 250, 1'b0);
    set_minimums(32'd1, 32'd0);
    run_phase(PACE_BOTH, 250, 1'b0);
    set_minimums(32'd0, 32'd0);
    run_phase(PACE_FULL, 250, 1'b0);
    set_minimums($urandom_range(0, 400), $urandom_range(0, 400));
    run_phase(PACE_SRC_GAPS, 250, 1'b0);
    set_minimums(32'hFFFF_FFFF, 32'd0);
    run_phase(PACE_BOTH, 250, 1'b0);

    if (error_count == 0) begin
      $display("[image_header_size_check_top] OK");
    end else begin
      $display("[image_header_size_check_top] ERROR");
    end
    $finish;
  end

endmodule
